>>> hdl/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and codes for the two-stack shared store.
// ----------------------------------------------------------------------------
package dssm_pkg;

	localparam int WORD_W = 32;

	// operation codes
	localparam logic [2:0] OP_PUSH_ONE = 3'd0;
	localparam logic [2:0] OP_PUSH_TWO = 3'd1;
	localparam logic [2:0] OP_POP_ONE  = 3'd2;
	localparam logic [2:0] OP_POP_TWO  = 3'd3;
	localparam logic [2:0] OP_LIST_ONE = 3'd4;
	localparam logic [2:0] OP_LIST_TWO = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic       accept;        // item taken this cycle
		logic [2:0] op;            // its operation
		logic       direct;        // load output with a status-only result
		logic [1:0] direct_status;
		logic       step;          // load output from read data, fetch next entry
	} dssm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic lower_empty;
		logic upper_empty;
		logic rem_one;             // entry in read data is the final one
	} dssm_sts_t;

endpackage

>>> hdl/dssm_ram.sv
// ----------------------------------------------------------------------------
// dssm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hdl/dssm_ctrl.sv
// ----------------------------------------------------------------------------
// dssm_ctrl
// Controller: input handshake, output valid and the read-drain sequence.
// ----------------------------------------------------------------------------
module dssm_ctrl import dssm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	output logic       out_valid,
	input  logic       out_ready,
	input  dssm_sts_t  sts,
	output dssm_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   drain_start;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		drain_start = 1'b0;
		if (in_valid && in_ready) begin
			cmd.accept = 1'b1;
			cmd.op     = operation;
			case (operation)
				OP_PUSH_ONE, OP_PUSH_TWO: begin
					cmd.direct        = 1'b1;
					cmd.direct_status = sts.full ? ST_FULL : ST_OK;
				end
				OP_POP_ONE, OP_LIST_ONE: begin
					if (sts.lower_empty) begin
						cmd.direct        = 1'b1;
						cmd.direct_status = ST_EMPTY;
					end else begin
						drain_start = 1'b1;
					end
				end
				OP_POP_TWO, OP_LIST_TWO: begin
					if (sts.upper_empty) begin
						cmd.direct        = 1'b1;
						cmd.direct_status = ST_EMPTY;
					end else begin
						drain_start = 1'b1;
					end
				end
				default: begin
					// unused codes: taken, no result
				end
			endcase
		end
		if (state_q == S_DRAIN && out_free) begin
			cmd.step = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (drain_start) begin
				state_q <= S_DRAIN;
			end else if (cmd.step && sts.rem_one) begin
				state_q <= S_IDLE;
			end
			if (cmd.direct || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_step_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == S_DRAIN))
		else $error("step outside drain");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.direct && cmd.step))
		else $error("two output loads in one cycle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("output valid dropped while stalled");
`endif

endmodule

>>> hdl/dssm_dp.sv
// ----------------------------------------------------------------------------
// dssm_dp
// Datapath: stack pointers, list cursor, word store and output register.
// ----------------------------------------------------------------------------
module dssm_dp import dssm_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dssm_cmd_t                cmd,
	output dssm_sts_t                sts,
	input  logic signed [WORD_W-1:0] push_value,
	output logic signed [WORD_W-1:0] word_out,
	output logic [1:0]               status,
	output logic                     last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] lower_q, lower_d;   // entries in stack one
	logic [CW-1:0] upper_q, upper_d;   // lowest entry of stack two
	logic [CW-1:0] rem_q, rem_d;       // entries left, incl. the one in read data
	logic [AW-1:0] cursor_q, cursor_d; // next address to read in a list
	logic          up_q, up_d;         // list direction
	logic [CW-1:0] lower_dec;
	logic [CW-1:0] upper_dec;
	logic [CW-1:0] upper_inc;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;

	assign lower_dec = lower_q - CW'(1);
	assign upper_dec = upper_q - CW'(1);
	assign upper_inc = upper_q + CW'(1);

	assign sts.full        = (lower_q == upper_q);
	assign sts.lower_empty = (lower_q == '0);
	assign sts.upper_empty = (upper_q == CW'(DEPTH));
	assign sts.rem_one     = (rem_q == CW'(1));

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = lower_q[AW-1:0];
		rd_en    = 1'b0;
		rd_addr  = cursor_q;
		lower_d  = lower_q;
		upper_d  = upper_q;
		cursor_d = cursor_q;
		rem_d    = rem_q;
		up_d     = up_q;
		if (cmd.accept && cmd.direct) begin
			if (cmd.op == OP_PUSH_ONE && !sts.full) begin
				wr_en   = 1'b1;
				wr_addr = lower_q[AW-1:0];
				lower_d = lower_q + CW'(1);
			end else if (cmd.op == OP_PUSH_TWO && !sts.full) begin
				wr_en   = 1'b1;
				wr_addr = upper_dec[AW-1:0];
				upper_d = upper_dec;
			end
		end else if (cmd.accept) begin
			case (cmd.op)
				OP_POP_ONE: begin
					rd_en   = 1'b1;
					rd_addr = lower_dec[AW-1:0];
					lower_d = lower_dec;
					rem_d   = CW'(1);
				end
				OP_POP_TWO: begin
					rd_en   = 1'b1;
					rd_addr = upper_q[AW-1:0];
					upper_d = upper_inc;
					rem_d   = CW'(1);
				end
				OP_LIST_ONE: begin
					rd_en    = 1'b1;
					rd_addr  = lower_dec[AW-1:0];
					cursor_d = lower_dec[AW-1:0] - AW'(1);
					up_d     = 1'b0;
					rem_d    = lower_q;
				end
				OP_LIST_TWO: begin
					rd_en    = 1'b1;
					rd_addr  = upper_q[AW-1:0];
					cursor_d = upper_inc[AW-1:0];
					up_d     = 1'b1;
					rem_d    = CW'(DEPTH) - upper_q;
				end
				default: begin
				end
			endcase
		end
		// fetch the next list entry as the current one moves to the output
		if (cmd.step && !sts.rem_one) begin
			rd_en    = 1'b1;
			rd_addr  = cursor_q;
			cursor_d = up_q ? (cursor_q + AW'(1)) : (cursor_q - AW'(1));
			rem_d    = rem_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= CW'(DEPTH);
			rem_q   <= '0;
		end else begin
			lower_q <= lower_d;
			upper_q <= upper_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		cursor_q <= cursor_d;
		up_q     <= up_d;
		if (cmd.direct) begin
			word_out <= '0;
			status   <= cmd.direct_status;
			last     <= 1'b1;
		end else if (cmd.step) begin
			word_out <= rd_data;
			status   <= ST_OK;
			last     <= sts.rem_one;
		end
	end

	dssm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef ASSERT_OFF
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(lower_q <= upper_q) && (upper_q <= CW'(DEPTH)))
		else $error("stack pointers crossed");
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("write and read in one cycle");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CW'(DEPTH))
		else $error("list count out of range");
`endif

endmodule

>>> hdl/dual_stack_shared_memory.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two stacks in one DEPTH-word store: stack one grows up from entry 0,
// stack two grows down from entry DEPTH-1. Push, pop and list per item.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | in_valid / in_ready  | operation, push_value
//  output   | out_valid / out_ready| word_out, status, last
//
//  Push, and pop or list of an empty stack: result loaded the cycle after the
//  item is taken; a new item can follow every cycle while out_ready is high.
//  Pop: entry goes via the registered read port, then the output register.
//  List of n entries: one entry per cycle while out_ready is high;
//  no item is taken until the final entry is loaded into the output register.
//  A stalled output holds its register; reset empties both stacks, the store
//  itself is not cleared.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory import dssm_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               operation,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] word_out,
	output logic [1:0]               status,
	output logic                     last
);

	dssm_cmd_t cmd;   // controller orders to the datapath
	dssm_sts_t sts;   // pointer flags back to the controller

	// handshake and sequencing
	dssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// pointers, store and output register
	dssm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.push_value (push_value),
		.word_out   (word_out),
		.status     (status),
		.last       (last)
	);

endmodule
